>>> rtl/lacm_pkg.sv
// Shared constants, types and back-end state encoding for the lag
// autocorrelation / mean squared drift core. No dependencies.
package lacm_pkg;

    localparam int unsigned DEF_MAX_LAGS    = 32;
    localparam int unsigned DEF_MAX_SAMPLES = 4096;
    localparam int unsigned DEF_SAMPLE_BITS = 16;

    localparam int unsigned CFG_W  = 6;
    localparam int unsigned LAG_W  = 5;
    localparam int unsigned MEAN_W = 32;

    localparam logic [CFG_W-1:0] NUM_LAGS_RST = 6'd32;

    typedef struct packed {
        logic last;
        logic keep;
    } item_ctl_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_DRAIN,
        BK_LOAD,
        BK_DIV,
        BK_EMIT,
        BK_CLEAR
    } back_state_t;

endpackage

>>> rtl/lacm_queue.sv
// Two-entry register queue between the front and back ends.
// Standalone; no package dependency.
module lacm_queue #(
    parameter int unsigned W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   fill_reg, fill_next;
    logic         do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/lacm_front.sv
// Front end: accepts samples, marks them kept or dropped against the
// sample limit, and queues them. Uses lacm_pkg and lacm_queue.
module lacm_front
    import lacm_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    input  logic                   s_last_sample,
    output logic                   q_valid,
    input  logic                   q_pop,
    output logic [SAMPLE_BITS-1:0] q_sample,
    output item_ctl_t              q_ctl
);

    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned QW = SAMPLE_BITS + $bits(item_ctl_t);

    logic [CW-1:0] cnt_reg, cnt_next;
    item_ctl_t     in_ctl;
    logic          accept;
    logic [QW-1:0] q_data;

    assign in_ctl.keep = (32'(cnt_reg) < MAX_SAMPLES);
    assign in_ctl.last = s_last_sample;
    assign accept      = s_valid && s_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            if (s_last_sample) begin
                cnt_next = '0;
            end else if (in_ctl.keep) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    lacm_queue #(.W(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(s_valid),
        .push_ready(s_ready),
        .push_data ({s_sample, in_ctl}),
        .pop_valid (q_valid),
        .pop_ready (q_pop),
        .pop_data  (q_data)
    );

    assign q_sample = q_data[QW-1 -: SAMPLE_BITS];
    assign q_ctl    = item_ctl_t'(q_data[$bits(item_ctl_t)-1:0]);

endmodule

>>> rtl/lacm_back.sv
// Back end: per-lag multiply/accumulate through a shared multiplier pair,
// serial dividers for the means, result register. Uses lacm_pkg.
module lacm_back
    import lacm_pkg::*;
#(
    parameter int unsigned MAX_LAGS    = DEF_MAX_LAGS,
    parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  logic [SAMPLE_BITS-1:0] q_sample,
    input  item_ctl_t              q_ctl,
    input  logic [CFG_W-1:0]       num_lags,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LAG_W-1:0]       m_lag,
    output logic [MEAN_W-1:0]      m_corr_mean,
    output logic [MEAN_W-1:0]      m_msd_mean,
    output logic                   m_no_pairs,
    output logic                   m_truncated,
    output logic                   m_last_result
);

    localparam int unsigned SB  = SAMPLE_BITS;
    localparam int unsigned KW  = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
    localparam int unsigned LW  = $clog2(MAX_LAGS + 1);
    localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned PW  = 2 * SB;
    localparam int unsigned SQW = 2 * SB + 1;
    localparam int unsigned PSW = 2 * SB + CW - 1;
    localparam int unsigned DW  = 2 * SB + CW;
    localparam int unsigned NW  = $clog2(DW + 1);

    back_state_t state_reg, state_next;

    logic signed [SB-1:0]  hist_reg [MAX_LAGS];
    logic signed [PSW-1:0] psum_reg [MAX_LAGS];
    logic [DW-1:0]         dsum_reg [MAX_LAGS];

    logic [KW-1:0]    k_reg;
    logic [CW-1:0]    cnt_reg;
    logic             ovf_reg;
    logic signed [SB-1:0] cur_x_reg;
    logic             cur_last_reg;
    logic [KW-1:0]    i_reg;

    logic             s1_en_reg;
    logic [KW-1:0]    s1_k_reg;
    logic signed [SB-1:0] s1_x_reg, s1_p_reg;
    logic signed [SB:0]   s1_d_reg;
    logic             s2_en_reg;
    logic [KW-1:0]    s2_k_reg;
    logic signed [PW-1:0] s2_prod_reg;
    logic [SQW-1:0]   s2_sq_reg;

    logic [NW-1:0]    dcnt_reg;
    logic [CW-1:0]    div_reg;
    logic [CW-1:0]    rem_p_reg, rem_d_reg;
    logic [DW-1:0]    quo_p_reg, quo_d_reg;
    logic             neg_reg;
    logic             nopair_reg;

    logic             m_valid_reg;
    logic [LAG_W-1:0] m_lag_reg;
    logic [MEAN_W-1:0] m_corr_reg, m_msd_reg;
    logic             m_nopair_reg, m_trunc_reg, m_last_reg;

    // control outputs
    logic pop_en, issue_en, last_k, pairs_ok, div_done, out_free, emit_en, last_lag;

    logic [KW-1:0]         k_prev;
    logic signed [SB-1:0]  partner;
    logic                  lag_ok;
    logic [LW-1:0]         lags_eff;
    logic signed [PSW-1:0] psum_sel;
    logic [PSW-1:0]        psum_mag;
    logic [CW:0]           trial_p, trial_d;
    logic                  ge_p, ge_d;
    logic [63:0]           qp_ext, qd_ext;
    logic [31:0]           i_ext;
    logic signed [2*SB+1:0] sq_full;

    assign k_prev  = k_reg - 1'b1;
    assign partner = (k_reg == '0) ? cur_x_reg : hist_reg[k_prev];
    assign lag_ok  = (k_reg == '0) || (32'(cnt_reg) >= 32'(k_reg));
    assign last_k  = (32'(k_reg) == MAX_LAGS - 1);

    always_comb begin
        if (num_lags == '0) begin
            lags_eff = LW'(1);
        end else if (32'(num_lags) > MAX_LAGS) begin
            lags_eff = LW'(MAX_LAGS);
        end else begin
            lags_eff = LW'(num_lags);
        end
    end

    assign psum_sel = psum_reg[i_reg];
    assign psum_mag = psum_sel[PSW-1] ? PSW'(-psum_sel) : PSW'(psum_sel);
    assign pairs_ok = (32'(cnt_reg) > 32'(i_reg));
    assign trial_p  = {rem_p_reg, quo_p_reg[DW-1]};
    assign trial_d  = {rem_d_reg, quo_d_reg[DW-1]};
    assign ge_p     = (trial_p >= {1'b0, div_reg});
    assign ge_d     = (trial_d >= {1'b0, div_reg});
    assign div_done = (32'(dcnt_reg) == DW - 1);
    assign out_free = !m_valid_reg || m_ready;
    assign i_ext    = 32'(i_reg);
    assign last_lag = ((i_ext + 32'd1) == 32'(lags_eff));
    assign qp_ext   = 64'(quo_p_reg);
    assign qd_ext   = 64'(quo_d_reg);
    assign sq_full  = s1_d_reg * s1_d_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    if (q_ctl.keep) begin
                        state_next = BK_ISSUE;
                    end else if (q_ctl.last) begin
                        state_next = BK_DRAIN;
                    end
                end
            end
            BK_ISSUE: begin
                if (last_k) begin
                    state_next = cur_last_reg ? BK_DRAIN : BK_IDLE;
                end
            end
            BK_DRAIN: begin
                if (!s1_en_reg && !s2_en_reg) begin
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD: begin
                state_next = pairs_ok ? BK_DIV : BK_EMIT;
            end
            BK_DIV: begin
                if (div_done) begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    state_next = last_lag ? BK_CLEAR : BK_LOAD;
                end
            end
            BK_CLEAR: begin
                state_next = BK_IDLE;
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        pop_en   = 1'b0;
        issue_en = 1'b0;
        emit_en  = 1'b0;
        unique case (state_reg)
            BK_IDLE:  pop_en   = q_valid;
            BK_ISSUE: issue_en = 1'b1;
            BK_EMIT:  emit_en  = out_free;
            default: begin
            end
        endcase
    end

    assign q_pop = pop_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            k_reg        <= '0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            i_reg        <= '0;
            s1_en_reg    <= 1'b0;
            s2_en_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            cur_last_reg <= 1'b0;
            for (int n = 0; n < MAX_LAGS; n++) begin
                hist_reg[n] <= '0;
                psum_reg[n] <= '0;
                dsum_reg[n] <= '0;
            end
        end else begin
            state_reg <= state_next;
            s1_en_reg <= issue_en && lag_ok;
            s2_en_reg <= s1_en_reg;

            if (pop_en) begin
                cur_last_reg <= q_ctl.last;
                k_reg        <= '0;
                if (!q_ctl.keep) begin
                    ovf_reg <= 1'b1;
                end
            end

            if (issue_en) begin
                k_reg <= k_reg + 1'b1;
                if (last_k) begin
                    for (int n = MAX_LAGS - 1; n > 0; n--) begin
                        hist_reg[n] <= hist_reg[n-1];
                    end
                    hist_reg[0] <= cur_x_reg;
                    cnt_reg     <= cnt_reg + 1'b1;
                end
            end

            if (s2_en_reg) begin
                psum_reg[s2_k_reg] <= psum_reg[s2_k_reg] + PSW'(s2_prod_reg);
                dsum_reg[s2_k_reg] <= dsum_reg[s2_k_reg] + DW'(s2_sq_reg);
            end

            if (state_reg == BK_DRAIN) begin
                i_reg <= '0;
            end

            if (emit_en) begin
                m_valid_reg <= 1'b1;
                i_reg       <= i_reg + 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (state_reg == BK_CLEAR) begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
                for (int n = 0; n < MAX_LAGS; n++) begin
                    hist_reg[n] <= '0;
                    psum_reg[n] <= '0;
                    dsum_reg[n] <= '0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (pop_en) begin
            cur_x_reg <= q_sample;
        end

        s1_k_reg <= k_reg;
        s1_x_reg <= cur_x_reg;
        s1_p_reg <= partner;
        s1_d_reg <= $signed({cur_x_reg[SB-1], cur_x_reg}) - $signed({partner[SB-1], partner});

        s2_k_reg    <= s1_k_reg;
        s2_prod_reg <= s1_x_reg * s1_p_reg;
        s2_sq_reg   <= sq_full[SQW-1:0];

        if (state_reg == BK_LOAD) begin
            dcnt_reg   <= '0;
            div_reg    <= cnt_reg - CW'(i_reg);
            rem_p_reg  <= '0;
            rem_d_reg  <= '0;
            quo_p_reg  <= DW'(psum_mag);
            quo_d_reg  <= dsum_reg[i_reg];
            neg_reg    <= psum_sel[PSW-1];
            nopair_reg <= !pairs_ok;
        end else if (state_reg == BK_DIV) begin
            dcnt_reg  <= dcnt_reg + 1'b1;
            rem_p_reg <= ge_p ? CW'(trial_p - {1'b0, div_reg}) : trial_p[CW-1:0];
            rem_d_reg <= ge_d ? CW'(trial_d - {1'b0, div_reg}) : trial_d[CW-1:0];
            quo_p_reg <= {quo_p_reg[DW-2:0], ge_p};
            quo_d_reg <= {quo_d_reg[DW-2:0], ge_d};
        end

        if (emit_en) begin
            m_lag_reg    <= i_ext[LAG_W-1:0];
            m_nopair_reg <= nopair_reg;
            m_trunc_reg  <= ovf_reg;
            m_last_reg   <= last_lag;
            if (nopair_reg) begin
                m_corr_reg <= '0;
                m_msd_reg  <= '0;
            end else begin
                m_corr_reg <= neg_reg ? -qp_ext[MEAN_W-1:0] : qp_ext[MEAN_W-1:0];
                m_msd_reg  <= qd_ext[MEAN_W-1:0];
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_lag         = m_lag_reg;
    assign m_corr_mean   = m_corr_reg;
    assign m_msd_mean    = m_msd_reg;
    assign m_no_pairs    = m_nopair_reg;
    assign m_truncated   = m_trunc_reg;
    assign m_last_result = m_last_reg;

endmodule

>>> rtl/lag_autocorrelation_and_msd_core.sv
// Top level of the lag autocorrelation / mean squared drift core.
// Uses lacm_pkg, lacm_front (with lacm_queue) and lacm_back.
//
//   channel | ports                                  | direction
//   cfg     | cfg_valid cfg_ready cfg_data[5:0]      | in  (num_lags)
//   s       | s_valid s_ready s_sample s_last_sample | in  (one sample)
//   m       | m_valid m_ready m_lag ... m_last_result| out (one per lag)
//
// In the back end a kept sample is popped and then issued one lag per cycle
// through the shared multiplier pair; a dropped sample is only popped.
// At run end each lag is loaded, divided by the bit-serial dividers (skipped when
// the lag has no pairs) and emitted, then the CLEAR state clears the run state.
// A two-entry queue lets the input side accept up to two samples while the back end works.
// aresetn is synchronous, active low; num_lags resets to 32.
module lag_autocorrelation_and_msd_core
    import lacm_pkg::*;
#(
    parameter int unsigned MAX_LAGS    = DEF_MAX_LAGS,
    parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    input  logic                   s_last_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LAG_W-1:0]       m_lag,
    output logic [MEAN_W-1:0]      m_corr_mean,
    output logic [MEAN_W-1:0]      m_msd_mean,
    output logic                   m_no_pairs,
    output logic                   m_truncated,
    output logic                   m_last_result
);

    logic [CFG_W-1:0]       num_lags_reg;
    logic                   q_valid, q_pop;
    logic [SAMPLE_BITS-1:0] q_sample;
    item_ctl_t              q_ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_lags_reg <= NUM_LAGS_RST;
        end else if (cfg_valid) begin
            num_lags_reg <= cfg_data;
        end
    end

    lacm_front #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_last_sample(s_last_sample),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_sample     (q_sample),
        .q_ctl        (q_ctl)
    );

    lacm_back #(
        .MAX_LAGS   (MAX_LAGS),
        .MAX_SAMPLES(MAX_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_sample     (q_sample),
        .q_ctl        (q_ctl),
        .num_lags     (num_lags_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_lag        (m_lag),
        .m_corr_mean  (m_corr_mean),
        .m_msd_mean   (m_msd_mean),
        .m_no_pairs   (m_no_pairs),
        .m_truncated  (m_truncated),
        .m_last_result(m_last_result)
    );

`ifndef NO_ASSERTIONS
    a_nopair_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_pairs |-> (m_corr_mean == '0) && (m_msd_mean == '0))
        else $error("no-pairs result carries nonzero means");

    a_lag0_msd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_lag == '0) && !m_no_pairs |-> (m_msd_mean == '0))
        else $error("lag zero drift not zero");

    a_lag0_corr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_lag == '0) && !m_no_pairs |-> !m_corr_mean[MEAN_W-1])
        else $error("lag zero correlation negative");
`endif

endmodule

>>> bench/tb_top.sv
// Testbench for lag_autocorrelation_and_msd_core: random and directed sample runs,
// results checked against a behavioral predictor in a scoreboard class.
// Depends on lacm_pkg and the core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lacm_pkg::*;

    localparam int NLAGS = 32;
    localparam int NMAX  = 4096;
    localparam longint LIMIT = 3000000;

    typedef struct {
        logic [4:0]  lag;
        logic [31:0] corr;
        logic [31:0] msd;
        logic        no_pairs;
        logic        trunc;
        logic        last;
    } lag_result_t;

    int errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    class corr_scoreboard;
        longint      hist[NLAGS];
        longint      psum[NLAGS];
        longint      dsum[NLAGS];
        int          count;
        bit          ovf;
        logic [5:0]  num_lags;
        lag_result_t pending[$];

        function new();
            clear_run();
            num_lags = NUM_LAGS_RST;
        endfunction

        function void clear_run();
            for (int k = 0; k < NLAGS; k++) begin
                hist[k] = 0;
                psum[k] = 0;
                dsum[k] = 0;
            end
            count = 0;
            ovf = 0;
        endfunction

        function void note_sample(input logic [15:0] smp, input logic last);
            longint x, p, d, q;
            int lags;
            lag_result_t r;
            x = longint'($signed(smp));
            if (count >= NMAX) begin
                ovf = 1;
            end else begin
                for (int k = 0; k < NLAGS; k++) begin
                    if (k == 0) p = x;
                    else if (count >= k) p = hist[k-1];
                    else continue;
                    psum[k] += x * p;
                    d = x - p;
                    dsum[k] += d * d;
                end
                for (int k = NLAGS - 1; k > 0; k--) hist[k] = hist[k-1];
                hist[0] = x;
                count++;
            end
            if (!last) return;
            lags = num_lags;
            if (lags == 0) lags = 1;
            if (lags > NLAGS) lags = NLAGS;
            for (int i = 0; i < lags; i++) begin
                r.lag = i[4:0];
                if (count > i) begin
                    q = psum[i] / (count - i);
                    r.corr = q[31:0];
                    q = dsum[i] / (count - i);
                    r.msd = q[31:0];
                    r.no_pairs = 0;
                end else begin
                    r.corr = 0;
                    r.msd = 0;
                    r.no_pairs = 1;
                end
                r.trunc = ovf;
                r.last = (i + 1 == lags);
                pending.push_back(r);
            end
            clear_run();
        endfunction

        task check_result(input lag_result_t got);
            lag_result_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result lag", got.lag, 0);
                return;
            end
            w = pending.pop_front();
            if (got.lag !== w.lag) report_mismatch("lag", got.lag, w.lag);
            if (got.corr !== w.corr) report_mismatch("corr_mean", got.corr, w.corr);
            if (got.msd !== w.msd) report_mismatch("msd_mean", got.msd, w.msd);
            if (got.no_pairs !== w.no_pairs) report_mismatch("no_pairs", got.no_pairs, w.no_pairs);
            if (got.trunc !== w.trunc) report_mismatch("truncated", got.trunc, w.trunc);
            if (got.last !== w.last) report_mismatch("last_result", got.last, w.last);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [15:0] s_sample = '0;
    logic        s_last_sample = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [4:0]  m_lag;
    logic [31:0] m_corr_mean, m_msd_mean;
    logic        m_no_pairs, m_truncated, m_last_result;

    lag_autocorrelation_and_msd_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .s_last_sample(s_last_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_lag(m_lag),
        .m_corr_mean(m_corr_mean), .m_msd_mean(m_msd_mean),
        .m_no_pairs(m_no_pairs), .m_truncated(m_truncated),
        .m_last_result(m_last_result)
    );

    corr_scoreboard sb = new();
    longint cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls
    always @(posedge aclk) begin
        lag_result_t r;
        if (aresetn && m_valid && m_ready) begin
            r.lag = m_lag;
            r.corr = m_corr_mean;
            r.msd = m_msd_mean;
            r.no_pairs = m_no_pairs;
            r.trunc = m_truncated;
            r.last = m_last_result;
            sb.check_result(r);
        end
        m_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 : (gap_len() == 0);
    end

    task automatic send_sample(input logic [15:0] smp, input logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1;
        s_sample <= smp;
        s_last_sample <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(smp, last);
    endtask

    task automatic wait_drained();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (2 * 16 + 13 + 2 + 40) @(posedge aclk);
    endtask

    task automatic write_lags(input logic [5:0] v);
        wait_drained();
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.num_lags = v;
        cfg_valid <= 0;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_run(input int n);
        for (int i = 0; i < n; i++) send_sample(rand_sample(), i == n - 1);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: extremes, short runs with lags lacking pairs, single sample
        send_sample(16'h8000, 0);
        send_sample(16'h8000, 0);
        send_sample(16'h7fff, 0);
        send_sample(16'h8000, 1);
        send_sample(16'h7fff, 1);
        write_lags(6'd0);
        send_sample(16'hffff, 0);
        send_sample(16'h0001, 1);
        write_lags(6'd63);
        send_sample(16'h1234, 0);
        send_sample(16'hedcb, 1);
        write_lags(6'd1);
        send_run(4);
        write_lags(6'd32);
        send_run(5);
        write_lags(6'd33);
        send_run(3);
        // random runs, lag count changed between runs
        for (int run = 0; run < 13; run++) begin
            if ($urandom_range(0, 2) == 0) write_lags(6'($urandom_range(0, 63)));
            if (run == 10) wait_drained();
            send_run($urandom_range(1, 20));
        end
        // lag register written mid-run has no effect until the last sample
        send_sample(16'h4000, 0);
        wait_drained();
        cfg_valid <= 1;
        cfg_data <= 6'd7;
        do @(posedge aclk); while (!cfg_ready);
        sb.num_lags = 6'd7;
        cfg_valid <= 0;
        send_sample(16'hc000, 1);
        wait_drained();
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
